[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Types, codes and helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Operation codes.
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // Pipeline layout: product, sum, prep, divider steps, output.
  localparam int NUM_DIV_STEPS = 17;
  localparam int STG_PROD      = 0;
  localparam int STG_SUM       = 1;
  localparam int STG_PREP      = 2;
  localparam int STG_DIV0      = 3;
  localparam int STG_OUT       = STG_DIV0 + NUM_DIV_STEPS;
  localparam int NUM_STAGES    = STG_OUT + 1;

  // Input item.
  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic        [1:0]  status;
  } out_t;

  // First stage: raw products and add/subtract sums.
  typedef struct packed {
    logic        [1:0]  mode;
    logic               divz;
    logic signed [16:0] s_re;
    logic signed [16:0] s_im;
    logic signed [31:0] p_rr;
    logic signed [31:0] p_ii;
    logic signed [31:0] p_ri;
    logic signed [31:0] p_ir;
    logic signed [31:0] d_rr;
    logic signed [31:0] d_ii;
  } prod_t;

  // Second stage: combined products.
  typedef struct packed {
    logic        [1:0]  mode;
    logic               divz;
    logic signed [16:0] s_re;
    logic signed [16:0] s_im;
    logic signed [32:0] m_re;
    logic signed [32:0] m_im;
    logic signed [32:0] n_re;
    logic signed [32:0] n_im;
    logic        [31:0] den;
  } sum_t;

  // Divider stage contents, with the finished add/sub/mul result riding along.
  typedef struct packed {
    logic        [1:0]  mode;
    logic               divz;
    logic signed [15:0] f_re;
    logic signed [15:0] f_im;
    logic               f_ovf;
    logic        [40:0] rem_re;
    logic        [40:0] rem_im;
    logic        [16:0] q_re;
    logic        [16:0] q_im;
    logic        [47:0] dsh;
    logic               povf_re;
    logic               povf_im;
    logic               neg_re;
    logic               neg_im;
  } div_t;

  // Saturated value with its flag.
  typedef struct packed {
    logic               ovf;
    logic signed [15:0] val;
  } sat_t;

  // Saturate a signed value to 16 bits.
  function automatic sat_t sat16(input logic signed [33:0] v);
    sat_t r;
    if (v > 34'sd32767) begin
      r.ovf = 1'b1;
      r.val = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r.ovf = 1'b1;
      r.val = 16'sh8000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and divide on signed Q8.8 pairs.
// ----------------------------------------------------------------------------
//  channel   ports                            payload
//  input     in_valid / in_ready / in_data    mode, a_re, a_im, b_re, b_im
//  output    out_valid / out_ready / out_data res_re, res_im, status
//
// One item enters per cycle unless an output stall has backed up to the input;
// an item accepted into the product stage then passes through the sum, prep,
// 17 restoring divider and output stages in turn to reach the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stall at the output backs up one stage at a time.
// Synchronous active-low reset clears all stage valid bits.
// ----------------------------------------------------------------------------
module complex_arith_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cau_pkg::out_t out_data
);

  logic [cau_pkg::NUM_STAGES-1:0] vld_r, vld_nxt, en;
  cau_pkg::sum_t                  sum_q;
  cau_pkg::div_t                  dchain [0:cau_pkg::NUM_DIV_STEPS];

  // Per-stage advance enables, from the output back.
  always_comb begin
    en[cau_pkg::NUM_STAGES-1] = !vld_r[cau_pkg::NUM_STAGES-1] || out_ready;
    for (int k = cau_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // Valid bits follow the data.
  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < cau_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[cau_pkg::STG_PROD];
  assign out_valid = vld_r[cau_pkg::STG_OUT];

  // Products and sums.
  cau_prod u_prod (
    .clk     (clk),
    .en_prod (en[cau_pkg::STG_PROD]),
    .en_sum  (en[cau_pkg::STG_SUM]),
    .in_data (in_data),
    .sum_q   (sum_q)
  );

  // Non-divide results and divider setup.
  cau_prep u_prep (
    .clk   (clk),
    .en    (en[cau_pkg::STG_PREP]),
    .sum_d (sum_q),
    .div_q (dchain[0])
  );

  // Divider stages.
  for (genvar j = 0; j < cau_pkg::NUM_DIV_STEPS; j++) begin : g_div
    cau_div_step u_step (
      .clk   (clk),
      .en    (en[cau_pkg::STG_DIV0+j]),
      .div_d (dchain[j]),
      .div_q (dchain[j+1])
    );
  end

  // Output register.
  cau_out u_out (
    .clk   (clk),
    .en    (en[cau_pkg::STG_OUT]),
    .div_d (dchain[cau_pkg::NUM_DIV_STEPS]),
    .out_q (out_data)
  );

endmodule

[rtl/cau_prod.sv]
// ----------------------------------------------------------------------------
// cau_prod
// Two stages: six 16x16 products and add/sub sums, then their combinations.
// ----------------------------------------------------------------------------
module cau_prod (
  input  logic          clk,
  input  logic          en_prod,
  input  logic          en_sum,
  input  cau_pkg::in_t  in_data,
  output cau_pkg::sum_t sum_q
);

  cau_pkg::prod_t     prod_r, prod_nxt;
  cau_pkg::sum_t      sum_r, sum_nxt;
  logic signed [15:0] ar, ai, br, bi;
  logic signed [16:0] ar17, ai17, br17, bi17;

  assign ar = in_data.a_re;
  assign ai = in_data.a_im;
  assign br = in_data.b_re;
  assign bi = in_data.b_im;
  assign ar17 = ar;
  assign ai17 = ai;
  assign br17 = br;
  assign bi17 = bi;

  // Products and the 17-bit sum or difference.
  always_comb begin
    prod_nxt.mode = in_data.mode;
    prod_nxt.divz = (br == 16'sd0) && (bi == 16'sd0);
    if (in_data.mode == cau_pkg::MODE_SUB) begin
      prod_nxt.s_re = ar17 - br17;
      prod_nxt.s_im = ai17 - bi17;
    end else begin
      prod_nxt.s_re = ar17 + br17;
      prod_nxt.s_im = ai17 + bi17;
    end
    prod_nxt.p_rr = ar * br;
    prod_nxt.p_ii = ai * bi;
    prod_nxt.p_ri = ar * bi;
    prod_nxt.p_ir = ai * br;
    prod_nxt.d_rr = br * br;
    prod_nxt.d_ii = bi * bi;
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod_r <= prod_nxt;
    end
  end

  // Real and imaginary combinations for multiply and divide.
  always_comb begin
    logic signed [32:0] rr, ii, ri, ir;
    rr = prod_r.p_rr;
    ii = prod_r.p_ii;
    ri = prod_r.p_ri;
    ir = prod_r.p_ir;
    sum_nxt.mode = prod_r.mode;
    sum_nxt.divz = prod_r.divz;
    sum_nxt.s_re = prod_r.s_re;
    sum_nxt.s_im = prod_r.s_im;
    sum_nxt.m_re = rr - ii;
    sum_nxt.m_im = ri + ir;
    sum_nxt.n_re = rr + ii;
    sum_nxt.n_im = ir - ri;
    sum_nxt.den  = $unsigned(prod_r.d_rr) + $unsigned(prod_r.d_ii);
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_q = sum_r;

endmodule

[rtl/cau_prep.sv]
// ----------------------------------------------------------------------------
// cau_prep
// Finishes add, subtract and multiply, and sets up the divider operands.
// ----------------------------------------------------------------------------
module cau_prep (
  input  logic          clk,
  input  logic          en,
  input  cau_pkg::sum_t sum_d,
  output cau_pkg::div_t div_q
);

  cau_pkg::div_t div_r, div_nxt;

  always_comb begin
    logic signed [33:0] t_re, t_im;
    cau_pkg::sat_t      f_re, f_im;
    logic        [32:0] mag_re, mag_im;
    logic        [40:0] nn_re, nn_im;
    logic        [48:0] dlim;

    // Multiply rounds half up in Q8.8; add and subtract pass straight through.
    if (sum_d.mode == cau_pkg::MODE_MUL) begin
      t_re = (34'(sum_d.m_re) + 34'sd128) >>> 8;
      t_im = (34'(sum_d.m_im) + 34'sd128) >>> 8;
    end else begin
      t_re = 34'(sum_d.s_re);
      t_im = 34'(sum_d.s_im);
    end
    f_re = cau_pkg::sat16(t_re);
    f_im = cau_pkg::sat16(t_im);

    // Divider: magnitude scaled by 256 plus half the denominator.
    mag_re = sum_d.n_re[32] ? 33'(-sum_d.n_re) : 33'(sum_d.n_re);
    mag_im = sum_d.n_im[32] ? 33'(-sum_d.n_im) : 33'(sum_d.n_im);
    nn_re  = 41'({mag_re[31:0], 8'd0}) + 41'(sum_d.den[31:1]);
    nn_im  = 41'({mag_im[31:0], 8'd0}) + 41'(sum_d.den[31:1]);
    dlim   = {sum_d.den, 17'd0};

    div_nxt.mode    = sum_d.mode;
    div_nxt.divz    = sum_d.divz;
    div_nxt.f_re    = f_re.val;
    div_nxt.f_im    = f_im.val;
    div_nxt.f_ovf   = f_re.ovf | f_im.ovf;
    div_nxt.rem_re  = nn_re;
    div_nxt.rem_im  = nn_im;
    div_nxt.q_re    = '0;
    div_nxt.q_im    = '0;
    div_nxt.dsh     = {sum_d.den, 16'd0};
    div_nxt.povf_re = {8'd0, nn_re} >= dlim;
    div_nxt.povf_im = {8'd0, nn_im} >= dlim;
    div_nxt.neg_re  = sum_d.n_re[32];
    div_nxt.neg_im  = sum_d.n_im[32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_q = div_r;

endmodule

[rtl/cau_div_step.sv]
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring division step for the real and imaginary quotients.
// ----------------------------------------------------------------------------
module cau_div_step (
  input  logic          clk,
  input  logic          en,
  input  cau_pkg::div_t div_d,
  output cau_pkg::div_t div_q
);

  cau_pkg::div_t div_r, div_nxt;

  // Subtract the shifted divisor where it fits and shift in a quotient bit.
  always_comb begin
    logic ge_re, ge_im;
    ge_re = {7'd0, div_d.rem_re} >= div_d.dsh;
    ge_im = {7'd0, div_d.rem_im} >= div_d.dsh;
    div_nxt        = div_d;
    div_nxt.rem_re = ge_re ? div_d.rem_re - div_d.dsh[40:0] : div_d.rem_re;
    div_nxt.rem_im = ge_im ? div_d.rem_im - div_d.dsh[40:0] : div_d.rem_im;
    div_nxt.q_re   = {div_d.q_re[15:0], ge_re};
    div_nxt.q_im   = {div_d.q_im[15:0], ge_im};
    div_nxt.dsh    = div_d.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_q = div_r;

endmodule

[rtl/cau_out.sv]
// ----------------------------------------------------------------------------
// cau_out
// Signs and saturates the quotients and selects the result item.
// ----------------------------------------------------------------------------
module cau_out (
  input  logic          clk,
  input  logic          en,
  input  cau_pkg::div_t div_d,
  output cau_pkg::out_t out_q
);

  cau_pkg::out_t out_r, out_nxt;

  always_comb begin
    logic signed [15:0] d_re, d_im;
    logic               o_re, o_im;
    logic        [16:0] nq_re, nq_im;

    nq_re = 17'd0 - div_d.q_re;
    nq_im = 17'd0 - div_d.q_im;

    // Real quotient.
    if (div_d.neg_re) begin
      o_re = div_d.povf_re || (div_d.q_re > 17'd32768);
      d_re = o_re ? 16'sh8000 : nq_re[15:0];
    end else begin
      o_re = div_d.povf_re || (div_d.q_re > 17'd32767);
      d_re = o_re ? 16'sh7fff : div_d.q_re[15:0];
    end

    // Imaginary quotient.
    if (div_d.neg_im) begin
      o_im = div_d.povf_im || (div_d.q_im > 17'd32768);
      d_im = o_im ? 16'sh8000 : nq_im[15:0];
    end else begin
      o_im = div_d.povf_im || (div_d.q_im > 17'd32767);
      d_im = o_im ? 16'sh7fff : div_d.q_im[15:0];
    end

    // Result selection.
    if (div_d.mode != cau_pkg::MODE_DIV) begin
      out_nxt.res_re = div_d.f_re;
      out_nxt.res_im = div_d.f_im;
      out_nxt.status = div_d.f_ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
    end else if (div_d.divz) begin
      out_nxt.res_re = '0;
      out_nxt.res_im = '0;
      out_nxt.status = cau_pkg::ST_DIV0;
    end else begin
      out_nxt.res_re = d_re;
      out_nxt.res_im = d_im;
      out_nxt.status = (o_re || o_im) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_q = out_r;

endmodule

[rtl/cau_checker.sv]
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input cau_pkg::out_t out_data
);

  // A waiting result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Divide by zero gives a zero result.
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == cau_pkg::ST_DIV0 |->
      out_data.res_re == 16'sd0 && out_data.res_im == 16'sd0)
    else $error("divide by zero result not zero");

  // An overflow status comes with a saturated part.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == cau_pkg::ST_OVF |->
      out_data.res_re == 16'sh7fff || out_data.res_re == 16'sh8000 ||
      out_data.res_im == 16'sh7fff || out_data.res_im == 16'sh8000)
    else $error("overflow status without saturated part");

  // No status code beyond divide by zero.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= cau_pkg::ST_DIV0)
    else $error("undefined status code");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
